[hdl/bsfc_pkg.sv]
// Shared constants and the CRC byte fold for the byte-stuffing framer.
package bsfc_pkg;

   localparam int unsigned JOB_DEPTH = 8;
   localparam int unsigned JOB_IDX_W = 3;
   localparam int unsigned JOB_CNT_W = 4;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   localparam logic [15:0] POLY_RESET = 16'h1021;
   localparam logic [15:0] INIT_RESET = 16'hFFFF;

   // register index, taken from paddr[2]
   localparam logic CSR_POLY = 1'b0;
   localparam logic CSR_INIT = 1'b1;

   typedef logic [JOB_DEPTH-1:0][7:0] job_bytes_type;

   // MSB-first CRC-16 update with one byte, no reflection
   function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b,
                                            logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hdl/byte_stuffing_framer_crc16_top.sv]
// Byte-stuffing framer with running CRC-16 and a byte serializer.
//
// Each payload item (data byte plus last-byte mark) becomes 1 to 8 link bytes:
// an opening 0x7E flag before the first byte of a frame, the byte itself
// (0x7D/0x7E escaped as 0x7D, byte^0x20), and on the last byte the CRC low and
// high bytes (escaped the same way) and a closing 0x7E with frame_end set.
// run_last marks the final link byte caused by each item. The CRC is MSB-first
// with generator crc_poly (offset 0x0) and start value crc_init (offset 0x4),
// no final XOR; crc_init is loaded at each frame start. Timing: an item is
// registered, then folded into the CRC and expanded into a job of up to eight
// bytes as it enters the job stage; the serializer sends one link byte per
// cycle while rsp_stall is low. An item makes 1 link byte plus 1 per escape,
// +1 for an opening flag, +3..5 for a frame tail. A new item is taken while
// the current job is still draining, so the output runs without gaps as long
// as items arrive. An accepted item passes the input register and then the
// job register before its first link byte appears.
module byte_stuffing_framer_crc16_top (
   input  logic        clock,
   input  logic        reset,
   // payload items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // link bytes
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // registers
   logic [15:0] crc_poly_ff, crc_poly_in;
   logic [15:0] crc_init_ff, crc_init_in;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_last_ff, in_last_in;

   // frame state
   logic [15:0] crc_ff, crc_in;
   logic        frame_open_ff, frame_open_in;

   // job (serializer) stage
   logic                               job_valid_ff, job_valid_in;
   bsfc_pkg::job_bytes_type            job_bytes_ff, job_bytes_in;
   logic [bsfc_pkg::JOB_IDX_W-1:0]     job_idx_ff, job_idx_in;
   logic [bsfc_pkg::JOB_IDX_W-1:0]     job_last_idx_ff, job_last_idx_in;
   logic                               job_end_ff, job_end_in;

   // expansion logic
   bsfc_pkg::job_bytes_type            exp_bytes;
   logic [bsfc_pkg::JOB_CNT_W-1:0]     exp_cnt;
   logic [bsfc_pkg::JOB_CNT_W-1:0]     exp_cnt_m1;
   logic [15:0]                        crc_start;
   logic [15:0]                        crc_next;
   logic [2:0][7:0]                    stuff_src;

   logic req_accept;
   logic job_at_end;
   logic job_done;
   logic job_load;
   logic csr_write;

   // ---------------------------------------------------------------------
   // register port: zero-wait, paddr[2] picks the register
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      crc_poly_in = crc_poly_ff;
      crc_init_in = crc_init_ff;
      if (csr_write) begin
         case (paddr[2])
            bsfc_pkg::CSR_POLY: crc_poly_in = pwdata[15:0];
            bsfc_pkg::CSR_INIT: crc_init_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         bsfc_pkg::CSR_POLY: prdata = {16'h0000, crc_poly_ff};
         bsfc_pkg::CSR_INIT: prdata = {16'h0000, crc_init_ff};
         default:            prdata = 32'h0000_0000;
      endcase
   end

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign job_at_end = (job_idx_ff == job_last_idx_ff);
   assign job_done   = job_valid_ff && !rsp_stall && job_at_end;
   // the registered item moves into the job stage once the current job
   // hands over its last byte (or there is none)
   assign job_load   = in_valid_ff && (!job_valid_ff || job_done);
   assign req_stall  = in_valid_ff && !job_load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end else if (job_load) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // CRC fold and expansion into link bytes
   // ---------------------------------------------------------------------
   assign crc_start = frame_open_ff ? crc_ff : crc_init_ff;
   assign crc_next  = bsfc_pkg::crc_fold(crc_start, in_byte_ff, crc_poly_ff);

   always_comb begin
      exp_bytes    = '0;
      exp_cnt      = '0;
      stuff_src[0] = in_byte_ff;
      stuff_src[1] = crc_next[7:0];
      stuff_src[2] = crc_next[15:8];

      if (!frame_open_ff) begin
         exp_bytes[exp_cnt[bsfc_pkg::JOB_IDX_W-1:0]] = bsfc_pkg::FLAG_BYTE;
         exp_cnt = exp_cnt + 1'b1;
      end

      // payload byte, then CRC low and high on the last byte
      for (int k = 0; k < 3; k++) begin
         if (k == 0 || in_last_ff) begin
            if (stuff_src[k] == bsfc_pkg::ESC_BYTE ||
                stuff_src[k] == bsfc_pkg::FLAG_BYTE) begin
               exp_bytes[exp_cnt[bsfc_pkg::JOB_IDX_W-1:0]] = bsfc_pkg::ESC_BYTE;
               exp_cnt = exp_cnt + 1'b1;
               exp_bytes[exp_cnt[bsfc_pkg::JOB_IDX_W-1:0]] =
                  stuff_src[k] ^ bsfc_pkg::ESC_XOR;
               exp_cnt = exp_cnt + 1'b1;
            end else begin
               exp_bytes[exp_cnt[bsfc_pkg::JOB_IDX_W-1:0]] = stuff_src[k];
               exp_cnt = exp_cnt + 1'b1;
            end
         end
      end

      if (in_last_ff) begin
         exp_bytes[exp_cnt[bsfc_pkg::JOB_IDX_W-1:0]] = bsfc_pkg::FLAG_BYTE;
         exp_cnt = exp_cnt + 1'b1;
      end
   end

   assign exp_cnt_m1 = exp_cnt - 1'b1;

   // frame state advances when an item enters the job stage
   always_comb begin
      crc_in        = crc_ff;
      frame_open_in = frame_open_ff;
      if (job_load) begin
         crc_in        = crc_next;
         frame_open_in = !in_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // serializer: while rsp_stall is low, one link byte per cycle
   // ---------------------------------------------------------------------
   always_comb begin
      job_valid_in    = job_valid_ff;
      job_bytes_in    = job_bytes_ff;
      job_idx_in      = job_idx_ff;
      job_last_idx_in = job_last_idx_ff;
      job_end_in      = job_end_ff;
      if (job_load) begin
         job_valid_in    = 1'b1;
         job_bytes_in    = exp_bytes;
         job_idx_in      = '0;
         job_last_idx_in = exp_cnt_m1[bsfc_pkg::JOB_IDX_W-1:0];
         job_end_in      = in_last_ff;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (job_valid_ff && !rsp_stall) begin
         job_idx_in = job_idx_ff + 1'b1;
      end
   end

   assign rsp_valid     = job_valid_ff;
   assign rsp_out_byte  = job_bytes_ff[job_idx_ff];
   assign rsp_run_last  = job_at_end;
   assign rsp_frame_end = job_end_ff && job_at_end;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff   <= bsfc_pkg::POLY_RESET;
         crc_init_ff   <= bsfc_pkg::INIT_RESET;
         in_valid_ff   <= 1'b0;
         frame_open_ff <= 1'b0;
         job_valid_ff  <= 1'b0;
      end else begin
         crc_poly_ff   <= crc_poly_in;
         crc_init_ff   <= crc_init_in;
         in_valid_ff   <= in_valid_in;
         frame_open_ff <= frame_open_in;
         job_valid_ff  <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff      <= in_byte_in;
      in_last_ff      <= in_last_in;
      crc_ff          <= crc_in;
      job_bytes_ff    <= job_bytes_in;
      job_idx_ff      <= job_idx_in;
      job_last_idx_ff <= job_last_idx_in;
      job_end_ff      <= job_end_in;
   end

`ifndef ASSERT_OFF
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_idx_ff <= job_last_idx_ff))
      else $error("serializer index past end of job");

   a_end_is_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_out_byte == bsfc_pkg::FLAG_BYTE))
      else $error("frame end on a byte that is not a flag");

   a_load_fills_job: assert property (@(posedge clock) disable iff (reset)
      job_load |=> (job_valid_ff && job_idx_ff == '0))
      else $error("job stage not filled after load");

   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      $fell(frame_open_ff) |-> $past(job_load && in_last_ff))
      else $error("frame closed without a last item");
`endif

endmodule
